[design/assert_macros.svh]
// assertion macros used by quantile_select_interpolate
// no dependencies; expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, quiet during reset
`define CHECK_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/qsi_pkg.sv]
// shared types and constants for the quantile select block
// no dependencies
package qsi_pkg;

	localparam int Q_BITS = 16;
	localparam logic [Q_BITS:0] Q_ONE = 17'h10000;
	localparam logic [Q_BITS:0] Q_RESET = 17'h08000;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctrl_t;

endpackage

[design/quantile_select_interpolate.sv]
// top level: sample loading, quantile position, shift-out and interpolation
// depends on qsi_pkg, qsi_chain, assert_macros.svh
//
// channel  | direction | handshake                  | payload
// sample   | in        | sample_valid/sample_stall  | sample_value, has_sample, last_sample
// result   | out       | result_valid/result_stall  | quantile_result, set_empty, set_overflow
// config   | in        | cfg_wr_en                  | cfg_wr_data
//
// a sample is sorted into the cell row in the transfer cycle if room is left, one item per cycle while in S_LOAD
// a close passes S_POS (lo = q*(n-1) >> 16), S_SCAN, S_MUL, S_FIN, an empty set S_POS, S_FIN:
// S_SCAN shifts the row headward one cell per cycle until lo, and lo + 1 if frac != 0, is seen
// no sample is taken between a close and its result entering the output register
// the output register holds a result under result_stall while loading goes on
// reset clears the control state and sets the fraction to one half
`include "assert_macros.svh"

module quantile_select_interpolate import qsi_pkg::*; #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [Q_BITS:0]                cfg_wr_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
	input  logic                           has_sample,
	input  logic                           last_sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [SAMPLE_WIDTH-1:0] quantile_result,
	output logic                           set_empty,
	output logic                           set_overflow
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int PW = Q_BITS + 1 + CW;
	localparam int DW = SW + 1;
	localparam int MW = DW + Q_BITS + 1;
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SAMPLES);

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_POS  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]             state_q;
	logic [Q_BITS:0]        qfrac_q;
	logic [CW-1:0]          count_q;
	logic                   ovf_q;
	logic                   empty_q;
	logic [CW-1:0]          lo_q;
	logic [Q_BITS-1:0]      frac_q;
	logic [CW-1:0]          idx_q;
	logic signed [SW-1:0]   a_q;
	logic signed [DW-1:0]   diff_q;
	logic signed [MW-1:0]   prod_q;
	logic                   out_valid_q;
	logic signed [SW-1:0]   out_res_q;
	logic                   out_empty_q;
	logic                   out_ovf_q;

	logic                   in_xfer;
	logic                   room;
	logic                   out_free;
	logic [Q_BITS:0]        qclamp;
	logic [PW-1:0]          pos;
	logic [CW-1:0]          lo_next;
	logic signed [SW-1:0]   head;
	cell_ctrl_t             ctrl;

	assign in_xfer = sample_valid && !sample_stall;
	assign sample_stall = state_q != S_LOAD;
	assign room = count_q < MAX_COUNT;
	assign out_free = !out_valid_q || !result_stall;

	// fractions above one saturate to the maximum
	assign qclamp = (qfrac_q > Q_ONE) ? Q_ONE : qfrac_q;
	assign pos = PW'(qclamp) * PW'(count_q - 1'b1);
	assign lo_next = CW'(lo_q + 1'b1);

	assign ctrl.ins = in_xfer && has_sample && room;
	assign ctrl.shift = state_q == S_SCAN;

	qsi_chain #(.MAX(MAX_SAMPLES), .SW(SW), .CW(CW)) u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.x     (sample_value),
		.count (count_q),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			qfrac_q <= Q_RESET;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				qfrac_q <= cfg_wr_data;
			end
			// a new result may load in the cycle the held one transfers
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (has_sample) begin
							if (room) begin
								count_q <= count_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (last_sample) begin
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					state_q <= (count_q == '0) ? S_FIN : S_SCAN;
				end
				S_SCAN: begin
					if ((idx_q == lo_q && frac_q == '0) || idx_q == lo_next) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_POS: begin
				empty_q <= count_q == '0;
				lo_q <= pos[Q_BITS +: CW];
				frac_q <= pos[Q_BITS-1:0];
				idx_q <= '0;
				a_q <= '0;
				diff_q <= '0;
			end
			S_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == lo_q) begin
					a_q <= head;
				end
				if (idx_q == lo_next) begin
					diff_q <= DW'(head) - DW'(a_q);
				end
			end
			S_MUL: begin
				prod_q <= $signed({1'b0, frac_q}) * diff_q;
			end
			S_FIN: begin
				if (out_free) begin
					// floor of the product over 2^16 comes from the arithmetic part-select
					out_res_q <= empty_q ? '0 :
						(frac_q == '0 ? a_q : a_q + prod_q[Q_BITS +: SW]);
					out_empty_q <= empty_q;
					out_ovf_q <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign quantile_result = out_res_q;
	assign set_empty = out_empty_q;
	assign set_overflow = out_ovf_q;

	`CHECK_ALWAYS(a_count_bound, !arst_n || count_q <= MAX_COUNT, "sample count above capacity")
	`CHECK_CLK(a_ovf_full, ovf_q |-> count_q == MAX_COUNT, "overflow with room left")
	`CHECK_CLK(a_rise_fin, $rose(result_valid) |-> $past(state_q == S_FIN), "result outside finish")
	`CHECK_CLK(a_empty_zero, (result_valid && set_empty) |-> quantile_result == '0, "empty set nonzero")

endmodule

[design/qsi_cell.sv]
// one cell of the sorted sample row: holds one sample
// depends on qsi_pkg
module qsi_cell import qsi_pkg::*; #(
	parameter int SW = 32,
	parameter int CW = 11,
	parameter int INDEX = 0
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic signed [SW-1:0] x,
	input  logic signed [SW-1:0] prev_val,
	input  logic signed [SW-1:0] next_val,
	input  logic                 prev_gt,
	input  logic [CW-1:0]        count,
	output logic signed [SW-1:0] val,
	output logic                 gt
);

	logic signed [SW-1:0] val_q;
	logic occ;
	logic prev_occ;

	assign occ = CW'(INDEX) < count;
	generate
		if (INDEX == 0) begin : g_head
			assign prev_occ = 1'b1;
		end else begin : g_body
			assign prev_occ = CW'(INDEX - 1) < count;
		end
	endgenerate

	assign gt = occ && (val_q > x);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			// larger neighbor below moves up, first larger or first free slot takes x
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || (prev_occ && !occ)) begin
				val_q <= x;
			end
		end else if (ctrl.shift) begin
			val_q <= next_val;
		end
	end

endmodule

[design/qsi_chain.sv]
// row of sample cells: sorted insertion and shift-out toward the head
// depends on qsi_pkg and qsi_cell
module qsi_chain import qsi_pkg::*; #(
	parameter int MAX = 1024,
	parameter int SW = 32,
	parameter int CW = 11
) (
	input  logic                 clk,
	input  cell_ctrl_t           ctrl,
	input  logic signed [SW-1:0] x,
	input  logic [CW-1:0]        count,
	output logic signed [SW-1:0] head
);

	logic signed [SW-1:0] vals [MAX];
	logic                 gts  [MAX];

	genvar i;
	generate
		for (i = 0; i < MAX; i++) begin : g_cell
			logic signed [SW-1:0] pv;
			logic signed [SW-1:0] nv;
			logic                 pg;
			if (i == 0) begin : g_first
				assign pv = '0;
				assign pg = 1'b0;
			end else begin : g_mid
				assign pv = vals[i-1];
				assign pg = gts[i-1];
			end
			if (i == MAX - 1) begin : g_last
				assign nv = '0;
			end else begin : g_inner
				assign nv = vals[i+1];
			end
			qsi_cell #(.SW(SW), .CW(CW), .INDEX(i)) u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.x        (x),
				.prev_val (pv),
				.next_val (nv),
				.prev_gt  (pg),
				.count    (count),
				.val      (vals[i]),
				.gt       (gts[i])
			);
		end
	endgenerate

	assign head = vals[0];

endmodule
